@@ rtl/core/rca_pkg.sv @@
// ----------------------------------------------------------------------------
// rca_pkg: shared types and constants of the rounded corner alpha mask
// Beat payloads, register indexes and reset values, fixed field widths and
// the square root pipeline geometry.
// ----------------------------------------------------------------------------
package rca_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned DIM_W    = 11;
  localparam int unsigned RADIUS_W = 18;
  localparam int unsigned CHAN_W   = 8;

  // Square root pipeline: squared distance padded to an even digit count
  localparam int unsigned D2_W          = 40;
  localparam int unsigned ROOT_W        = D2_W / 2;
  localparam int unsigned REM_W         = ROOT_W + 4;
  localparam int unsigned SQ_DIGITS_PER = 2;
  localparam int unsigned SQ_STAGES     = ROOT_W / SQ_DIGITS_PER;

  // Configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CORNER_RADIUS = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH   = 11'd64;
  localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT  = 11'd64;
  localparam logic [RADIUS_W-1:0] RST_CORNER_RADIUS = 18'd2340;

  // What happens to the alpha of a pixel
  typedef enum logic [1:0] {
    ACT_KEEP,
    ACT_ZERO,
    ACT_SCALE
  } action_e;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;
    logic [CHAN_W-1:0]  alpha_in;
  } in_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
  } out_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pix_t;

  // One beat inside the square root pipeline
  typedef struct packed {
    pix_t                pix;
    action_e             act;
    logic [RADIUS_W-1:0] r;
    logic [D2_W-1:0]     d2;
    logic [ROOT_W-1:0]   root;
    logic [REM_W-1:0]    rem;
  } sq_t;

endpackage

@@ rtl/core/rounded_corner_alpha_mask.sv @@
// ----------------------------------------------------------------------------
// rounded_corner_alpha_mask: antialiased rounded rectangle alpha mask
// Clears or feathers the alpha of pixels in the four image corners.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one pixel per beat with its
//   column and row. Output channel out_valid_o/out_ready_i carries the same
//   pixel with color unchanged and alpha masked, one beat per input beat,
//   in order.
//   Configuration (width, height, radius in Q.RADIUS_FRACTION_BITS) is
//   written through cfg_we_i/cfg_index_i/cfg_wdata_i while the stream is
//   idle; an unknown index is ignored.
//   Throughput is one beat per cycle while the receiver keeps out_ready_i
//   high. The pipeline has 4 geometry stages, a 10 stage square root (two
//   digits per stage), a factor stage and the output register.
//   Every stage holds its own valid bit, so empty stages fill while the
//   receiver stalls; the input stalls only when all 16 stages are full.
//   Reset empties the pipeline and loads width 64, height 64, radius 2340.
// ----------------------------------------------------------------------------
module rounded_corner_alpha_mask #(
  parameter int unsigned MAX_DIMENSION        = 1024,
  parameter int unsigned RADIUS_FRACTION_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [rca_pkg::RADIUS_W-1:0]      cfg_wdata_i,
  // pixel input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rca_pkg::in_beat_t                 in_data_i,
  // pixel output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rca_pkg::out_beat_t                out_data_o
);

  localparam int unsigned F    = RADIUS_FRACTION_BITS;
  localparam int unsigned PW   = rca_pkg::DIM_W + F;
  localparam int unsigned RW   = rca_pkg::RADIUS_W;
  localparam int unsigned CW   = (PW > RW) ? PW : RW;
  localparam int unsigned SQS  = rca_pkg::SQ_STAGES;
  localparam int unsigned NS   = SQS + 6;
  localparam int unsigned SHR  = (F > 8) ? F - 8 : 0;
  localparam int unsigned SHL  = (F < 8) ? 8 - F : 0;
  localparam int unsigned RND  = (F > 8) ? (1 << (F - 9)) : 0;
  localparam logic [RW-1:0] ONE_R = RW'(1) << F;
  localparam logic [rca_pkg::DIM_W-1:0] MAX_DIM_SAT =
    (MAX_DIMENSION > 2047) ? 11'd2047 : 11'(MAX_DIMENSION);

  typedef struct packed {
    rca_pkg::pix_t               pix;
    logic                        pass;
    logic [RW-1:0]               r;
    logic [PW-1:0]               fx;
    logic [PW-1:0]               fy;
    logic [rca_pkg::DIM_W-1:0]   w;
    logic [rca_pkg::DIM_W-1:0]   h;
  } s1_t;

  typedef struct packed {
    rca_pkg::pix_t pix;
    logic          keep;
    logic [RW-1:0] r;
    logic [RW-1:0] dx;
    logic [RW-1:0] dy;
  } s2_t;

  typedef struct packed {
    rca_pkg::pix_t   pix;
    logic            keep;
    logic            feather;
    logic [RW-1:0]   r;
    logic [2*RW-1:0] dx2;
    logic [2*RW-1:0] dy2;
    logic [2*RW-1:0] outer2;
    logic [2*RW-1:0] inner2;
  } s3_t;

  typedef struct packed {
    rca_pkg::pix_t    pix;
    rca_pkg::action_e act;
    logic [7:0]       f8;
  } fs_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [rca_pkg::DIM_W-1:0] width_q, height_q;
  logic [RW-1:0]             radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rca_pkg::RST_IMAGE_WIDTH;
      height_q <= rca_pkg::RST_IMAGE_HEIGHT;
      radius_q <= rca_pkg::RST_CORNER_RADIUS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rca_pkg::REG_IMAGE_WIDTH:   width_q  <= cfg_wdata_i[rca_pkg::DIM_W-1:0];
        rca_pkg::REG_IMAGE_HEIGHT:  height_q <= cfg_wdata_i[rca_pkg::DIM_W-1:0];
        rca_pkg::REG_CORNER_RADIUS: radius_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when its successor loads
  // --------------------------------------------------------------------------
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  logic [NS-1:0] v_in;

  assign en[NS-1] = !v_q[NS-1] || out_ready_i;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign v_in = {v_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // --------------------------------------------------------------------------
  // Stage 1: saturate dimensions, clamp radius, place the pixel center
  // --------------------------------------------------------------------------
  s1_t s1_d, s1_q;
  logic [rca_pkg::DIM_W-1:0] w_sat, h_sat, m_sat;
  logic [PW-1:0]             rmax;

  always_comb begin
    w_sat = (width_q > MAX_DIM_SAT) ? MAX_DIM_SAT : width_q;
    h_sat = (height_q > MAX_DIM_SAT) ? MAX_DIM_SAT : height_q;
    m_sat = (w_sat < h_sat) ? w_sat : h_sat;
    rmax  = {m_sat, {F{1'b0}}} >> 1;

    s1_d.pix.red   = in_data_i.red_in;
    s1_d.pix.green = in_data_i.green_in;
    s1_d.pix.blue  = in_data_i.blue_in;
    s1_d.pix.alpha = in_data_i.alpha_in;
    s1_d.pass = (w_sat == '0) || (h_sat == '0) || (radius_q == '0) ||
                ({1'b0, in_data_i.column} >= w_sat) ||
                ({1'b0, in_data_i.row} >= h_sat);
    s1_d.r  = (CW'(radius_q) < CW'(rmax)) ? radius_q : rmax[RW-1:0];
    s1_d.fx = PW'({in_data_i.column, 1'b1, {(F-1){1'b0}}});
    s1_d.fy = PW'({in_data_i.row, 1'b1, {(F-1){1'b0}}});
    s1_d.w  = w_sat;
    s1_d.h  = h_sat;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) s1_q <= s1_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: find the corner square and the offsets from the circle center
  // --------------------------------------------------------------------------
  s2_t s2_d, s2_q;
  logic [CW-1:0] right, bottom, fxc, fyc, rc, dxw, dyw;
  logic          x_lo, x_hi, y_lo, y_hi;

  always_comb begin
    rc     = CW'(s1_q.r);
    fxc    = CW'(s1_q.fx);
    fyc    = CW'(s1_q.fy);
    right  = CW'({s1_q.w, {F{1'b0}}}) - rc;
    bottom = CW'({s1_q.h, {F{1'b0}}}) - rc;
    x_lo   = fxc < rc;
    x_hi   = fxc > right;
    y_lo   = fyc < rc;
    y_hi   = fyc > bottom;
    dxw    = x_lo ? rc - fxc : fxc - right;
    dyw    = y_lo ? rc - fyc : fyc - bottom;

    s2_d.pix  = s1_q.pix;
    s2_d.keep = s1_q.pass || !(x_lo || x_hi) || !(y_lo || y_hi);
    s2_d.r    = s1_q.r;
    s2_d.dx   = dxw[RW-1:0];
    s2_d.dy   = dyw[RW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) s2_q <= s2_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: square the offsets and both edge radii
  // --------------------------------------------------------------------------
  s3_t           s3_d, s3_q;
  logic [RW-1:0] inner;

  always_comb begin
    s3_d.pix     = s2_q.pix;
    s3_d.keep    = s2_q.keep;
    s3_d.feather = s2_q.r > ONE_R;
    s3_d.r       = s2_q.r;
    inner        = s3_d.feather ? s2_q.r - ONE_R : '0;
    s3_d.dx2     = (2*RW)'(s2_q.dx) * (2*RW)'(s2_q.dx);
    s3_d.dy2     = (2*RW)'(s2_q.dy) * (2*RW)'(s2_q.dy);
    s3_d.outer2  = (2*RW)'(s2_q.r) * (2*RW)'(s2_q.r);
    s3_d.inner2  = (2*RW)'(inner) * (2*RW)'(inner);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) s3_q <= s3_d;
  end

  // --------------------------------------------------------------------------
  // Stage 4: sum the squared distance and classify against the edge band
  // --------------------------------------------------------------------------
  rca_pkg::sq_t      s4_d, s4_q;
  logic [2*RW:0]     d2;

  always_comb begin
    d2 = {1'b0, s3_q.dx2} + {1'b0, s3_q.dy2};
    s4_d.pix  = s3_q.pix;
    s4_d.r    = s3_q.r;
    s4_d.d2   = rca_pkg::D2_W'(d2);
    s4_d.root = '0;
    s4_d.rem  = '0;
    if (s3_q.keep) begin
      s4_d.act = rca_pkg::ACT_KEEP;
    end else if (s3_q.feather) begin
      if (d2 <= {1'b0, s3_q.inner2}) s4_d.act = rca_pkg::ACT_KEEP;
      else if (d2 >= {1'b0, s3_q.outer2}) s4_d.act = rca_pkg::ACT_ZERO;
      else s4_d.act = rca_pkg::ACT_SCALE;
    end else begin
      s4_d.act = (d2 <= {1'b0, s3_q.outer2}) ? rca_pkg::ACT_KEEP : rca_pkg::ACT_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) s4_q <= s4_d;
  end

  // --------------------------------------------------------------------------
  // Stages 5..14: square root, two result digits per stage
  // --------------------------------------------------------------------------
  rca_pkg::sq_t sq_in [SQS];
  rca_pkg::sq_t sq_d  [SQS];
  rca_pkg::sq_t sq_q  [SQS];

  assign sq_in[0] = s4_q;
  for (genvar g = 1; g < SQS; g++) begin : g_sq_link
    assign sq_in[g] = sq_q[g-1];
  end

  always_comb begin
    rca_pkg::sq_t             cur;
    logic [rca_pkg::REM_W-1:0] rem_sh;
    logic [rca_pkg::REM_W-1:0] trial;
    for (int g = 0; g < SQS; g++) begin
      cur = sq_in[g];
      for (int d = 0; d < rca_pkg::SQ_DIGITS_PER; d++) begin
        rem_sh = {cur.rem[rca_pkg::REM_W-3:0], cur.d2[rca_pkg::D2_W-1 -: 2]};
        trial  = rca_pkg::REM_W'({cur.root, 2'b01});
        cur.d2 = cur.d2 << 2;
        if (rem_sh >= trial) begin
          cur.rem  = rem_sh - trial;
          cur.root = {cur.root[rca_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          cur.rem  = rem_sh;
          cur.root = {cur.root[rca_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      sq_d[g] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < SQS; g++) begin
      if (en[4+g]) sq_q[g] <= sq_d[g];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 15: coverage factor from radius minus distance, in Q0.8
  // --------------------------------------------------------------------------
  fs_t                       fs_d, fs_q;
  rca_pkg::sq_t              sq_last;
  logic [RW-1:0]             diff_raw, diff;
  logic [8:0]                f8;

  always_comb begin
    sq_last  = sq_q[SQS-1];
    diff_raw = sq_last.r - sq_last.root[RW-1:0];
    if (sq_last.root >= rca_pkg::ROOT_W'(sq_last.r)) diff = '0;
    else if (diff_raw > ONE_R) diff = ONE_R;
    else diff = diff_raw;
    f8 = 9'(((32'(diff) + RND) >> SHR) << SHL);

    fs_d.pix = sq_last.pix;
    fs_d.f8  = f8[7:0];
    fs_d.act = sq_last.act;
    if (sq_last.act == rca_pkg::ACT_SCALE) begin
      if (f8 == '0) fs_d.act = rca_pkg::ACT_ZERO;
      else if (f8[8]) fs_d.act = rca_pkg::ACT_KEEP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-2]) fs_q <= fs_d;
  end

  // --------------------------------------------------------------------------
  // Stage 16: scale alpha and hold the output beat
  // --------------------------------------------------------------------------
  rca_pkg::out_beat_t out_d, out_q;
  logic [15:0]        prod;

  always_comb begin
    prod            = {8'd0, fs_q.pix.alpha} * {8'd0, fs_q.f8} + 16'd128;
    out_d.red_out   = fs_q.pix.red;
    out_d.green_out = fs_q.pix.green;
    out_d.blue_out  = fs_q.pix.blue;
    unique case (fs_q.act)
      rca_pkg::ACT_KEEP:  out_d.alpha_out = fs_q.pix.alpha;
      rca_pkg::ACT_ZERO:  out_d.alpha_out = '0;
      rca_pkg::ACT_SCALE: out_d.alpha_out = prod[15:8];
      default:            out_d.alpha_out = fs_q.pix.alpha;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

@@ verif/alpha_mask_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_mask_checker: pixel stream scoreboard for the rounded corner mask
// Watches the register port and both pixel channels. Every accepted input
// beat is run through a local corner mask predictor and queued. Every output
// beat is compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module alpha_mask_checker
  import rca_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [RADIUS_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_beat_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_beat_t           out_data_i,
  output int                  pending_o,
  output int                  errors_o
);

  localparam longint MAX_DIM = 1024;
  // one pixel in Q.8; the alpha factor is Q0.8, so it needs no rescaling
  localparam longint ONE_PX  = 256;

  logic [DIM_W-1:0]    width_q;
  logic [DIM_W-1:0]    height_q;
  logic [RADIUS_W-1:0] radius_q;
  out_beat_t           masked_pixels_q[$];
  out_beat_t           want;
  int                  fail_count  = 0;
  int                  outstanding = 0;

  assign pending_o = outstanding;
  assign errors_o  = fail_count;

  // floor of the square root, one result bit at a time
  function automatic longint floor_sqrt(longint v);
    longint root;
    longint trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (longint'(1) << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // alpha after the corner mask under the current register values
  function automatic logic [CHAN_W-1:0] corner_alpha(longint col, longint row, longint a);
    longint w, h, r, fx, fy, right_x, bottom_y, dx, dy;
    longint d2, outer2, inner_r, inner2, diff;
    bit     feathered;
    w = (width_q > MAX_DIM) ? MAX_DIM : longint'(width_q);
    h = (height_q > MAX_DIM) ? MAX_DIM : longint'(height_q);
    if (w == 0 || h == 0 || radius_q == 0 || col >= w || row >= h) return CHAN_W'(a);
    // clamp the radius to half the smaller side
    r = ((w < h ? w : h) * ONE_PX) >> 1;
    if (longint'(radius_q) < r) r = longint'(radius_q);
    fx       = col * ONE_PX + ONE_PX / 2;
    fy       = row * ONE_PX + ONE_PX / 2;
    right_x  = w * ONE_PX - r;
    bottom_y = h * ONE_PX - r;
    // only pixel centers inside a corner square are measured
    if (fx < r) dx = r - fx;
    else if (fx > right_x) dx = fx - right_x;
    else return CHAN_W'(a);
    if (fy < r) dy = r - fy;
    else if (fy > bottom_y) dy = fy - bottom_y;
    else return CHAN_W'(a);
    d2        = dx * dx + dy * dy;
    outer2    = r * r;
    inner_r   = r - ONE_PX;
    feathered = inner_r > 0;
    inner2    = feathered ? inner_r * inner_r : 0;
    if (d2 <= (feathered ? inner2 : outer2)) return CHAN_W'(a);
    if (!feathered || d2 >= outer2) return '0;
    // feather band: scale by radius minus distance, clamped to one pixel
    diff = r - floor_sqrt(d2);
    if (diff < 0) diff = 0;
    if (diff > ONE_PX) diff = ONE_PX;
    if (diff == 0) return '0;
    if (diff >= ONE_PX) return CHAN_W'(a);
    return CHAN_W'((a * diff + 128) >> 8);
  endfunction

  function automatic void check_field(string name, logic [CHAN_W-1:0] exp_val,
                                      logic [CHAN_W-1:0] got_val);
    if (got_val !== exp_val) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
    end
  endfunction

  // track registers, queue predictions, compare output beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      radius_q <= RST_CORNER_RADIUS;
      masked_pixels_q.delete();
      outstanding = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_IMAGE_WIDTH:   width_q  <= cfg_wdata_i[DIM_W-1:0];
          REG_IMAGE_HEIGHT:  height_q <= cfg_wdata_i[DIM_W-1:0];
          REG_CORNER_RADIUS: radius_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (masked_pixels_q.size() == 0) begin
          fail_count++;
          $error("output beat with no pixel pending");
        end else begin
          want = masked_pixels_q.pop_front();
          check_field("red_out", want.red_out, out_data_i.red_out);
          check_field("green_out", want.green_out, out_data_i.green_out);
          check_field("blue_out", want.blue_out, out_data_i.blue_out);
          check_field("alpha_out", want.alpha_out, out_data_i.alpha_out);
        end
      end
      if (in_valid_i && in_ready_i) begin
        want.red_out   = in_data_i.red_in;
        want.green_out = in_data_i.green_in;
        want.blue_out  = in_data_i.blue_in;
        want.alpha_out = corner_alpha(longint'(in_data_i.column),
                                      longint'(in_data_i.row),
                                      longint'(in_data_i.alpha_in));
        masked_pixels_q.insert(masked_pixels_q.size(), want);
      end
      outstanding = masked_pixels_q.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: rounded corner alpha mask
// Streams pixels through the mask under a series of image sizes and radii,
// with random gaps on the input side and random stalls on the output side.
// A directed set hits the corners, the feather band and pixels outside the
// image; the rest aims mostly at the corner bands. The checker scores it.
// ----------------------------------------------------------------------------
module testbench;
  import rca_pkg::*;

  localparam logic [1:0] REG_SPARE          = 2'd3;
  localparam int         SETTLE_CYCLES      = 24;
  localparam int         PIXELS_PER_SETTING = 122;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [1:0]          cfg_index   = REG_IMAGE_WIDTH;
  logic [RADIUS_W-1:0] cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  in_beat_t            in_data     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  out_beat_t           out_data;
  int                  pending;
  int                  errors;
  int                  pixels_sent = 0;
  int                  settings_run = 1;
  int                  rx_hold     = 0;
  bit                  tx_steady   = 1'b0;
  bit                  rx_steady   = 1'b0;
  logic [DIM_W-1:0]    cur_w       = RST_IMAGE_WIDTH;
  logic [DIM_W-1:0]    cur_h       = RST_IMAGE_HEIGHT;
  logic [RADIUS_W-1:0] cur_r       = RST_CORNER_RADIUS;

  rounded_corner_alpha_mask u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  alpha_mask_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap(bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // stall the output side at random
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rx_hold = pick_gap(rx_steady);
    end
  end

  // bias coordinates toward both edges, where the corners are
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned dim, int unsigned band);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (dim > 1024) dim = 1024;
    if (dim == 0 || roll == 9) return COORD_W'($urandom_range(0, 1023));
    if (band > dim - 1) band = dim - 1;
    if (roll < 4) return COORD_W'($urandom_range(0, band));
    if (roll < 8) return COORD_W'(dim - 1 - $urandom_range(0, band));
    return COORD_W'($urandom_range(0, dim - 1));
  endfunction

  function automatic in_beat_t random_pixel();
    in_beat_t    px;
    int unsigned band;
    int unsigned roll;
    band        = (cur_r >> 8) + 2;
    px.column   = pick_coord(32'(cur_w), band);
    px.row      = pick_coord(32'(cur_h), band);
    px.red_in   = 8'($urandom);
    px.green_in = 8'($urandom);
    px.blue_in  = 8'($urandom);
    roll        = $urandom_range(0, 9);
    px.alpha_in = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : 8'($urandom);
    return px;
  endfunction

  // hold the beat until it is accepted
  task automatic send_pixel(in_beat_t px);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic send(int col, int row, int red, int green, int blue, int alpha);
    in_beat_t px;
    px.column   = COORD_W'(col);
    px.row      = COORD_W'(row);
    px.red_in   = CHAN_W'(red);
    px.green_in = CHAN_W'(green);
    px.blue_in  = CHAN_W'(blue);
    px.alpha_in = CHAN_W'(alpha);
    send_pixel(px);
  endtask

  // drop valid and wait until every output beat is in
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_setting(int unsigned w, int unsigned h, int unsigned r);
    settle();
    cur_w     = DIM_W'(w);
    cur_h     = DIM_W'(h);
    cur_r     = RADIUS_W'(r);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= RADIUS_W'(cur_w);
    @(posedge clk_i);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_wdata <= RADIUS_W'(cur_h);
    @(posedge clk_i);
    cfg_index <= REG_CORNER_RADIUS;
    cfg_wdata <= cur_r;
    @(posedge clk_i);
    // an unmapped index must leave the registers alone
    cfg_index <= REG_SPARE;
    cfg_wdata <= '1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    settings_run++;
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    repeat (PIXELS_PER_SETTING) send_pixel(random_pixel());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: 64 x 64, radius a little over 9 pixels
    send(0, 0, 255, 0, 255, 255);
    send(63, 0, 0, 255, 0, 255);
    send(0, 63, 255, 255, 255, 128);
    send(63, 63, 0, 0, 0, 255);
    send(32, 32, 17, 34, 51, 200);
    send(8, 8, 1, 2, 3, 255);
    send(9, 9, 4, 5, 6, 99);
    send(64, 10, 7, 8, 9, 255);
    send(10, 64, 10, 11, 12, 255);
    send(1023, 1023, 255, 255, 255, 255);
    send(512, 0, 128, 64, 32, 255);
    // pixels in and near the feather band of the top left and bottom right corners
    send(2, 3, 90, 91, 92, 255);
    send(3, 2, 93, 94, 95, 128);
    send(1, 4, 96, 97, 98, 1);
    send(9, 0, 99, 100, 101, 255);
    send(0, 9, 102, 103, 104, 0);
    send(8, 1, 105, 106, 107, 77);
    send(61, 60, 108, 109, 110, 255);
    send(60, 61, 111, 112, 113, 3);
    repeat (PIXELS_PER_SETTING) send_pixel(random_pixel());

    run_setting(64, 48, 4096);
    run_setting(1, 1, 255);
    run_setting(8, 8, 131072);
    run_setting(1024, 1024, 262143);
    run_setting(2047, 600, 20000);
    run_setting(0, 64, 2340);
    run_setting(100, 0, 2340);
    run_setting(100, 100, 0);
    run_setting(32, 32, 256);
    run_setting(32, 32, 257);
    run_setting(1, 1024, 512);
    run_setting(1024, 3, 1000);
    run_setting($urandom_range(1, 1024), $urandom_range(1, 1024), $urandom_range(0, 131072));
    run_setting($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 262143));
    settle();

    $display("sent %0d pixels under %0d image and radius settings,", pixels_sent, settings_run);
    $display("including zero, hard, feathered and clamped radii and oversize images");
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop if the stream hangs
  initial begin
    #10ms;
    $display("timed out with %0d pixels sent", pixels_sent);
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rca_pkg.sv
rtl/core/rounded_corner_alpha_mask.sv
verif/alpha_mask_checker.sv
verif/testbench.sv
